[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/fwrs_pkg.sv]
// types, constants and helpers of the fenwick range-sum table
`timescale 1ns / 1ps

package fwrs_pkg;

   localparam int IdxW  = 10;
   localparam int SizeW = 11;
   localparam int PosW  = 12;
   localparam int DataW = 32;
   localparam int ResetSizeNominal = 1024;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_QUERY = 1'b1
   } fwrs_cmd_type;

   typedef struct packed {
      logic                    cmd;
      logic [IdxW-1:0]         first_index;
      logic [IdxW-1:0]         last_index;
      logic signed [DataW-1:0] delta;
   } fwrs_item_type;

   typedef struct packed {
      logic signed [DataW-1:0] range_sum;
      logic                    index_error;
   } fwrs_result_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } fwrs_status_type;

   // lowest set bit of a tree position
   function automatic logic [PosW-1:0] low_bit(input logic [PosW-1:0] p);
      return p & (~p + 1'b1);
   endfunction

endpackage

[hdl/fwrs_ifs.sv]
// channel interfaces: request items, result items and size register writes
`timescale 1ns / 1ps

interface fwrs_req_if import fwrs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [IdxW-1:0]         first_index;
   logic [IdxW-1:0]         last_index;
   logic signed [DataW-1:0] delta;

   modport source (output valid, cmd, first_index, last_index, delta, input ready);
   modport sink   (input valid, cmd, first_index, last_index, delta, output ready);
endinterface

interface fwrs_rsp_if import fwrs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] range_sum;
   logic                    index_error;

   modport source (output valid, range_sum, index_error, input ready);
   modport sink   (input valid, range_sum, index_error, output ready);
endinterface

interface fwrs_csr_if import fwrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SizeW-1:0] size_in_use;

   modport source (output valid, size_in_use, input ready);
   modport sink   (input valid, size_in_use, output ready);
endinterface

[hdl/fwrs_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module fwrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fwrs_engine.sv]
// tree walker: clearing pass, point update and range query over the node ram
`timescale 1ns / 1ps

module fwrs_engine import fwrs_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [SizeW-1:0] size,
   input  logic             cfg_clear,
   input  fwrs_item_type    item,
   input  logic             item_valid,
   output fwrs_result_type  result,
   output logic             result_valid,
   input  logic             result_ready,
   output fwrs_status_type  status
);

   localparam int AW       = $clog2(MAX_ENTRIES);
   localparam int SizeCap  = (MAX_ENTRIES < (2 ** SizeW) - 1) ? MAX_ENTRIES : (2 ** SizeW) - 1;
   localparam int WideW    = (AW > PosW) ? AW : PosW;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_UPD_RD,
      S_UPD_WR,
      S_QRY,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ptr_ff, clr_ptr_in;
   logic [PosW-1:0]         pos_a_ff, pos_a_in;
   logic [PosW-1:0]         pos_b_ff, pos_b_in;
   logic signed [DataW-1:0] delta_ff, delta_in;
   logic signed [DataW-1:0] acc_ff, acc_in;
   logic                    pend_ff, pend_in;
   logic                    pend_sub_ff, pend_sub_in;
   logic signed [DataW-1:0] sum_ff, sum_in;
   logic                    err_ff, err_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DataW-1:0]        wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [DataW-1:0]        rd_data;

   logic                    upd_err;
   logic                    qry_err;
   logic [PosW-1:0]         pos_size;

   // tree node p lives at ram entry p-1
   function automatic logic [AW-1:0] addr_of(input logic [PosW-1:0] p);
      logic [WideW-1:0] w;
      w = WideW'(p - 1'b1);
      return w[AW-1:0];
   endfunction

   assign pos_size = {1'b0, size};
   assign upd_err  = {1'b0, item.first_index} >= size;
   assign qry_err  = upd_err || ({1'b0, item.last_index} >= size);

   always_comb begin
      state_in    = state_ff;
      clr_ptr_in  = clr_ptr_ff;
      pos_a_in    = pos_a_ff;
      pos_b_in    = pos_b_ff;
      delta_in    = delta_ff;
      acc_in      = acc_ff;
      pend_in     = pend_ff;
      pend_sub_in = pend_sub_ff;
      sum_in      = sum_ff;
      err_in      = err_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_ptr_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = addr_of(pos_a_ff);

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ptr_ff == AW'(SizeCap - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               sum_in = '0;
               err_in = 1'b0;
               if (item.cmd == CMD_ADD) begin
                  if (upd_err) begin
                     err_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     pos_a_in = PosW'(item.first_index) + 1'b1;
                     delta_in = item.delta;
                     state_in = S_UPD_RD;
                  end
               end else begin
                  if (qry_err) begin
                     err_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     pos_a_in = PosW'(item.last_index) + 1'b1;
                     pos_b_in = PosW'(item.first_index);
                     acc_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_QRY;
                  end
               end
            end
         end
         S_UPD_RD: begin
            rd_en    = 1'b1;
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = addr_of(pos_a_ff);
            wr_data  = rd_data + delta_ff;
            pos_a_in = pos_a_ff + low_bit(pos_a_ff);
            if (pos_a_in > pos_size) begin
               state_in = S_DONE;
            end else begin
               state_in = S_UPD_RD;
            end
         end
         S_QRY: begin
            // data of the read issued last cycle lands now
            if (pend_ff) begin
               acc_in = pend_sub_ff ? acc_ff - signed'(rd_data) : acc_ff + signed'(rd_data);
            end
            if (pos_a_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = addr_of(pos_a_ff);
               pos_a_in    = pos_a_ff - low_bit(pos_a_ff);
               pend_in     = 1'b1;
               pend_sub_in = 1'b0;
            end else if (pos_b_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = addr_of(pos_b_ff);
               pos_b_in    = pos_b_ff - low_bit(pos_b_ff);
               pend_in     = 1'b1;
               pend_sub_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  sum_in   = acc_ff;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (result_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_clear) begin
         state_in   = S_CLEAR;
         clr_ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ptr_ff  <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ptr_ff  <= clr_ptr_in;
         pend_ff     <= pend_in;
      end
      pos_a_ff    <= pos_a_in;
      pos_b_ff    <= pos_b_in;
      delta_ff    <= delta_in;
      acc_ff      <= acc_in;
      pend_sub_ff <= pend_sub_in;
      sum_ff      <= sum_in;
      err_ff      <= err_in;
   end

   fwrs_ram #(
      .WIDTH (DataW),
      .DEPTH (MAX_ENTRIES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign result.range_sum   = sum_ff;
   assign result.index_error = err_ff;
   assign result_valid       = (state_ff == S_DONE);
   assign status.clearing    = (state_ff == S_CLEAR);
   assign status.idle        = (state_ff == S_IDLE);

endmodule

[hdl/fenwick_range_sum_table.sv]
// top level of the fenwick range-sum table
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   cmd, first_index, last_index, delta
//   rsp_ch   out  valid/ready   range_sum, index_error
//   csr_ch   in   valid/ready   size_in_use (ready while idle or clearing)
//
// an update reads and then writes back each tree node on its path, up to 11 nodes
// at the default size of 1024; a query reads one node per cycle over both prefix paths,
// up to 20 reads at that size; an index error goes straight to the result.
// after reset and after every size write the first min(MAX_ENTRIES, 2047) entries of
// the node ram are swept to zero with req_ch.ready low; size writes wait while an item
// is in progress, and a pending size write holds off the next item.
// the output register lets the next item start while a result waits on rsp_ch.ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fenwick_range_sum_table import fwrs_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   fwrs_req_if.sink    req_ch,
   fwrs_rsp_if.source  rsp_ch,
   fwrs_csr_if.sink    csr_ch
);

   localparam int SizeCap   = (MAX_ENTRIES < (2 ** SizeW) - 1) ? MAX_ENTRIES : (2 ** SizeW) - 1;
   localparam int ResetSize = (ResetSizeNominal < SizeCap) ? ResetSizeNominal : SizeCap;

   logic [SizeW-1:0]        size_ff, size_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] rsp_sum_ff;
   logic                    rsp_err_ff;

   logic                    csr_write;
   fwrs_item_type           item;
   fwrs_result_type         eng_result;
   logic                    eng_result_valid;
   logic                    out_free;
   fwrs_status_type         eng_status;

   assign csr_ch.ready = eng_status.idle || eng_status.clearing;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // oversized writes saturate to the ram depth, at most 2047
   always_comb begin
      size_in = size_ff;
      if (csr_write) begin
         if (csr_ch.size_in_use > SizeW'(SizeCap)) begin
            size_in = SizeW'(SizeCap);
         end else begin
            size_in = csr_ch.size_in_use;
         end
      end
   end

   assign item.cmd         = req_ch.cmd;
   assign item.first_index = req_ch.first_index;
   assign item.last_index  = req_ch.last_index;
   assign item.delta       = req_ch.delta;
   assign req_ch.ready     = eng_status.idle && !csr_ch.valid;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_result_valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SizeW'(ResetSize);
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (eng_result_valid && out_free) begin
         rsp_sum_ff <= eng_result.range_sum;
         rsp_err_ff <= eng_result.index_error;
      end
   end

   fwrs_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .size         (size_ff),
      .cfg_clear    (csr_write),
      .item         (item),
      .item_valid   (req_ch.valid && req_ch.ready),
      .result       (eng_result),
      .result_valid (eng_result_valid),
      .result_ready (out_free),
      .status       (eng_status)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.range_sum   = rsp_sum_ff;
   assign rsp_ch.index_error = rsp_err_ff;

   `ASSERT_IMPLY(a_no_item_while_clearing, clock, reset, eng_status.clearing, !req_ch.ready, "item taken during clearing pass")
   `ASSERT_NEXT(a_size_write_starts_clear, clock, reset, csr_write, eng_status.clearing, "size write did not start clearing pass")
   `ASSERT_ALWAYS(a_size_capped, clock, reset, size_ff <= SizeW'(SizeCap), "size register above ram depth")
   `ASSERT_IMPLY(a_error_sum_zero, clock, reset, rsp_ch.valid && rsp_ch.index_error, rsp_ch.range_sum == '0, "error item with nonzero sum")

endmodule
